### sv/ple_pkg.sv
// Package for the positional list engine: request and status codes,
// field widths and the control struct broadcast to the element cells.
// No dependencies.
package ple_pkg;

  localparam int ValueW = 32;
  localparam int PosW   = 5;
  localparam int CountW = 5;
  localparam int ModeW  = 3;
  localparam int StatW  = 2;

  localparam logic [ModeW-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [ModeW-1:0] MODE_INS_BACK  = 3'd1;
  localparam logic [ModeW-1:0] MODE_INS_POS   = 3'd2;
  localparam logic [ModeW-1:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [ModeW-1:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [ModeW-1:0] MODE_DEL_POS   = 3'd5;

  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_FULL   = 2'd1;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd2;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PosW-1:0]   idx;
    logic [ValueW-1:0] value;
  } cell_ctl_t;

endpackage

### sv/positional_list_engine.sv
// Top level of the positional list engine: request decode, element count,
// result register and the chain of element cells.
// Depends on ple_pkg and ple_cell.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit values in a
// row of cells, one cell per element, front in cell 0. Inserts and deletes
// at any position shift all affected cells in the same clock edge that
// accepts them, so one item is accepted per cycle whenever the
// result register is empty or being drained. The result for an item appears
// on the master side the cycle after it is accepted. The list is empty after
// reset; no clearing pass is needed.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[2:0], value[34:3], position[39:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], element_count[6:2], removed_value[38:7], zero
);

  localparam logic [CountW-1:0] CapW = CountW'(CAPACITY);

  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;
  logic [PosW-1:0]   position;
  logic              accept;

  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic [StatW-1:0]  status;
  logic              do_ins;
  logic              do_del;
  logic [PosW-1:0]   idx;
  cell_ctl_t         ctl;

  logic [ValueW-1:0] cell_data [CAPACITY];
  logic [ValueW-1:0] sel_chain [CAPACITY+1];

  logic              out_valid;
  logic [StatW-1:0]  out_status;
  logic [CountW-1:0] out_count;
  logic [ValueW-1:0] out_removed;

  assign mode     = s_tdata[2:0];
  assign value    = s_tdata[34:3];
  assign position = s_tdata[39:35];
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    status = ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    unique case (mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        idx = (mode == MODE_INS_FRONT) ? '0 : count;
        if (count >= CapW) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      MODE_INS_POS: begin
        idx = position - PosW'(1);
        if (position == '0 || {1'b0, position} > ({1'b0, count} + 6'd1)) begin
          status = ST_BADPOS;
        end else if (count >= CapW) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      MODE_DEL_FRONT, MODE_DEL_BACK: begin
        idx = (mode == MODE_DEL_FRONT) ? '0 : count - CountW'(1);
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          do_del = 1'b1;
        end
      end
      MODE_DEL_POS: begin
        idx = position - PosW'(1);
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (position == '0 || position > count) begin
          status = ST_BADPOS;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CountW'(1);
    end else if (do_del) begin
      count_next = count - CountW'(1);
    end
  end

  assign ctl.ins   = accept && do_ins;
  assign ctl.del   = accept && do_del;
  assign ctl.idx   = idx;
  assign ctl.value = value;

  assign sel_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueW-1:0] left_data;
    logic [ValueW-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end
    ple_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_data (left_data),
      .right_data(right_data),
      .sel_in    (sel_chain[i]),
      .data      (cell_data[i]),
      .sel_out   (sel_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= status;
      out_count   <= count_next;
      out_removed <= do_del ? sel_chain[CAPACITY] : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_removed, out_count, out_status};

endmodule

### sv/ple_cell.sv
// One element cell of the positional list engine chain.
// Depends on ple_pkg for the control struct and widths.
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [ValueW-1:0] left_data,
  input  logic [ValueW-1:0] right_data,
  input  logic [ValueW-1:0] sel_in,
  output logic [ValueW-1:0] data,
  output logic [ValueW-1:0] sel_out
);

  localparam logic [PosW-1:0] IdxW = PosW'(IDX);

  logic [ValueW-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (IdxW == ctl.idx) begin
        data_next = ctl.value;
      end else if (IdxW > ctl.idx) begin
        data_next = left_data;
      end
    end else if (ctl.del && IdxW >= ctl.idx) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign sel_out = sel_in | ((IdxW == ctl.idx) ? data : '0);

endmodule

### dv/tb_positional_list_engine.sv
// Self-checking bench for positional_list_engine: a directed table, then random runs of
// inserts, deletes and noise, checked against the table or an in-bench list model.
// Depends on ple_pkg and the engine RTL.
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int RAND_ITEMS    = 1600;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          pos;
  } list_req_t;

  typedef struct packed {
    logic [StatW-1:0]         status;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] removed;
  } list_result_t;

  typedef struct packed {
    list_req_t    req;
    logic         typed;
    list_result_t want;
  } dir_row_t;

  typedef enum int {SEG_FILL, SEG_SHRINK, SEG_MIXED, SEG_NOISE} seg_kind_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic [ValueW-1:0] list_vals [CAPACITY];
  int unsigned       list_len = 0;

  list_result_t pending_results [$];
  dir_row_t     dir_rows [$];

  int items_accepted = 0;
  int results_seen   = 0;
  int err_count      = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  bit no_idle        = 1'b0;

  positional_list_engine #(.CAPACITY(CAPACITY)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void insert_at(int unsigned idx, logic [ValueW-1:0] v);
    for (int unsigned i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
    list_vals[idx] = v;
    list_len++;
  endfunction

  function automatic logic [ValueW-1:0] remove_at(int unsigned idx);
    logic [ValueW-1:0] v;
    v = list_vals[idx];
    for (int unsigned i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return v;
  endfunction

  function automatic list_result_t apply_request(list_req_t req);
    list_result_t res;
    res = '0;
    res.status = ST_OK;
    case (req.mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (list_len >= CAPACITY) res.status = ST_FULL;
        else insert_at((req.mode == MODE_INS_FRONT) ? 0 : list_len, req.value);
      end
      MODE_INS_POS: begin
        if (req.pos < 1 || req.pos > list_len + 1) res.status = ST_BADPOS;
        else if (list_len >= CAPACITY) res.status = ST_FULL;
        else insert_at(req.pos - 1, req.value);
      end
      MODE_DEL_FRONT, MODE_DEL_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.removed = remove_at((req.mode == MODE_DEL_FRONT) ? 0 : list_len - 1);
      end
      MODE_DEL_POS: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (req.pos < 1 || req.pos > list_len) res.status = ST_BADPOS;
        else res.removed = remove_at(req.pos - 1);
      end
      default: ;
    endcase
    res.count = CountW'(list_len);
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic list_req_t pick_request(seg_kind_t kind);
    list_req_t   r;
    int unsigned hi;
    case (kind)
      SEG_FILL:   r.mode = ModeW'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
      SEG_SHRINK: r.mode = ModeW'($urandom_range(MODE_DEL_FRONT, MODE_DEL_POS));
      SEG_MIXED:  r.mode = ModeW'($urandom_range(MODE_INS_FRONT, MODE_DEL_POS));
      default:    r.mode = ModeW'($urandom_range(MODE_INS_FRONT, MODE_SPARE_7));
    endcase
    hi = (r.mode <= MODE_INS_POS) ? list_len + 1 : list_len;
    if (hi == 0) hi = 1;
    if (kind == SEG_NOISE || $urandom_range(0, 9) == 0) r.pos = PosW'($urandom_range(0, 31));
    else r.pos = PosW'($urandom_range(1, hi));
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       r.value = 32'h8000_0000;
        1:       r.value = 32'h7FFF_FFFF;
        2:       r.value = 32'h0000_0000;
        default: r.value = 32'hFFFF_FFFF;
      endcase
    end else begin
      r.value = $urandom();
    end
    return r;
  endfunction

  task automatic add_row(input logic [ModeW-1:0] mode, input logic [ValueW-1:0] value,
                         input logic [PosW-1:0] pos, input logic typed,
                         input logic [StatW-1:0] status, input logic [CountW-1:0] count,
                         input logic [ValueW-1:0] removed);
    dir_row_t row;
    row.req   = '{mode, value, pos};
    row.typed = typed;
    row.want  = '{status, count, removed};
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input list_req_t req, input logic typed,
                           input list_result_t want);
    int           gap;
    list_result_t pred;
    gap = idle_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {req.pos, req.value, req.mode};
    do @(posedge clk); while (!s_tready);
    pred = apply_request(req);
    pending_results.push_back(typed ? want : pred);
    items_accepted++;
  endtask

  task automatic settle_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < items_accepted);
  endtask

  task automatic check_result(input logic [39:0] word);
    list_result_t got;
    list_result_t want;
    got.status  = word[1:0];
    got.count   = word[6:2];
    got.removed = word[38:7];
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: status %0d element_count %0d removed_value %0d",
             got.status, got.count, got.removed);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        err_count++;
      end
      if (got.count != want.count) begin
        $error("element_count: expected %0d, got %0d", want.count, got.count);
        err_count++;
      end
      if (got.removed != want.removed) begin
        $error("removed_value: expected %0d, got %0d", want.removed, got.removed);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  initial begin : receiver
    int gap;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    seg_kind_t kind;
    int        seg;
    int        seg_len;
    add_row(MODE_DEL_FRONT, 32'h0000_1234, 5'd0,  1'b1, ST_EMPTY,  5'd0, 32'h0);
    add_row(MODE_DEL_BACK,  32'hFFFF_FFFF, 5'd31, 1'b1, ST_EMPTY,  5'd0, 32'h0);
    add_row(MODE_DEL_POS,   32'h0,         5'd1,  1'b1, ST_EMPTY,  5'd0, 32'h0);
    add_row(MODE_DEL_POS,   32'h0,         5'd0,  1'b1, ST_EMPTY,  5'd0, 32'h0);
    add_row(MODE_INS_POS,   32'h1,         5'd0,  1'b1, ST_BADPOS, 5'd0, 32'h0);
    add_row(MODE_INS_POS,   32'h1,         5'd2,  1'b1, ST_BADPOS, 5'd0, 32'h0);
    add_row(MODE_INS_POS,   32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,     5'd1, 32'h0);
    add_row(MODE_INS_FRONT, 32'h8000_0000, 5'd0,  1'b1, ST_OK,     5'd2, 32'h0);
    add_row(MODE_INS_BACK,  32'hFFFF_FFFF, 5'd31, 1'b1, ST_OK,     5'd3, 32'h0);
    add_row(MODE_INS_BACK,  32'h0000_0000, 5'd0,  1'b1, ST_OK,     5'd4, 32'h0);
    add_row(MODE_INS_POS,   32'hAAAA_AAAA, 5'd3,  1'b0, ST_OK,     5'd0, 32'h0);
    add_row(MODE_SPARE_6,   32'hFFFF_FFFF, 5'd31, 1'b1, ST_OK,     5'd5, 32'h0);
    add_row(MODE_SPARE_7,   32'h5555_5555, 5'd1,  1'b1, ST_OK,     5'd5, 32'h0);
    add_row(MODE_DEL_POS,   32'h0,         5'd0,  1'b1, ST_BADPOS, 5'd5, 32'h0);
    add_row(MODE_DEL_POS,   32'h0,         5'd6,  1'b1, ST_BADPOS, 5'd5, 32'h0);
    add_row(MODE_DEL_POS,   32'h0,         5'd3,  1'b0, ST_OK,     5'd0, 32'h0);
    add_row(MODE_DEL_FRONT, 32'h0,         5'd0,  1'b1, ST_OK,     5'd3, 32'h8000_0000);
    add_row(MODE_DEL_BACK,  32'h0,         5'd0,  1'b1, ST_OK,     5'd2, 32'h0);
    add_row(MODE_INS_POS,   32'h1234_5678, 5'd31, 1'b1, ST_BADPOS, 5'd2, 32'h0);
    add_row(MODE_DEL_POS,   32'h0,         5'd2,  1'b1, ST_OK,     5'd1, 32'hFFFF_FFFF);
    add_row(MODE_DEL_POS,   32'h0,         5'd1,  1'b1, ST_OK,     5'd0, 32'h7FFF_FFFF);
    add_row(MODE_INS_POS,   32'h5555_5555, 5'd1,  1'b1, ST_OK,     5'd1, 32'h0);
    add_row(MODE_DEL_BACK,  32'h0,         5'd0,  1'b1, ST_OK,     5'd0, 32'h5555_5555);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    settle_results();

    seg = 0;
    while (items_accepted < dir_rows.size() + RAND_ITEMS) begin
      kind    = seg_kind_t'($urandom_range(SEG_FILL, SEG_NOISE));
      no_idle = (seg == 0) || ($urandom_range(0, 4) == 0);
      seg_len = (seg == 0) ? 40 : $urandom_range(8, 40);
      if (seg == 0 || $urandom_range(0, 11) == 0) hold_requests++;
      for (int n = 0; n < seg_len; n++) send_item(pick_request(kind), 1'b0, '0);
      if (seg == 1 || $urandom_range(0, 7) == 0) settle_results();
      seg++;
    end

    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      $error("%0d expected results never arrived", pending_results.size());
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
